/* src/fwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fwc_pkg;

  localparam int MAX_N  = 64;
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int DIST_W = 16;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 6;

  localparam logic [CNT_W-1:0] N_RESET = CNT_W'(MAX_N);
  localparam logic [CNT_W-1:0] N_MAX   = CNT_W'(MAX_N);

  typedef logic signed [DIST_W-1:0] dist_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam dist_t NO_EDGE = 16'sd9999;
  localparam logic signed [DIST_W:0] SUM_FLOOR = -17'sd32768;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    dist_t wdata;
    logic  re;
    addr_t raddr_a;
    addr_t raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic  upd;
    dist_t value;
  } relax_t;

endpackage

`default_nettype wire

/* src/fwc_dist_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwc_dist_mem (
  input  wire               clk,
  input  fwc_pkg::mem_req_t req,
  output fwc_pkg::dist_t    rd_a,
  output fwc_pkg::dist_t    rd_b
);

  fwc_pkg::dist_t mem_r [fwc_pkg::DEPTH];
  fwc_pkg::dist_t rd_a_r;
  fwc_pkg::dist_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_a_r <= mem_r[req.raddr_a];
      rd_b_r <= mem_r[req.raddr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

`default_nettype wire

/* src/fwc_relax_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwc_relax_alu (
  input  fwc_pkg::dist_t  ik,
  input  fwc_pkg::dist_t  kj,
  input  fwc_pkg::dist_t  ij,
  output fwc_pkg::relax_t relax
);

  logic                             no_edge;
  logic signed [fwc_pkg::DIST_W:0]  sum;
  logic signed [fwc_pkg::DIST_W:0]  sum_sat;
  logic signed [fwc_pkg::DIST_W:0]  ij_ext;

  always_comb begin
    no_edge = (ik >= fwc_pkg::NO_EDGE) || (kj >= fwc_pkg::NO_EDGE);
    sum     = $signed({ik[fwc_pkg::DIST_W-1], ik}) + $signed({kj[fwc_pkg::DIST_W-1], kj});
    sum_sat = (sum < fwc_pkg::SUM_FLOOR) ? fwc_pkg::SUM_FLOOR : sum;
    ij_ext  = $signed({ij[fwc_pkg::DIST_W-1], ij});
    relax.upd   = !no_edge && (sum_sat < ij_ext);
    relax.value = sum_sat[fwc_pkg::DIST_W-1:0];
  end

endmodule

`default_nettype wire

/* src/fwc_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwc_sequencer (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       in_kind,
  input  wire  [fwc_pkg::POS_W-1:0]        in_row,
  input  wire  [fwc_pkg::POS_W-1:0]        in_col,
  input  wire  signed [fwc_pkg::DIST_W-1:0] in_weight,
  output logic                             out_valid,
  input  wire                              out_ready,
  output fwc_pkg::dist_t                   out_distance,
  input  wire                              cfg_we,
  input  wire  [fwc_pkg::CNT_W-1:0]        cfg_data,
  output fwc_pkg::mem_req_t                mem_req,
  input  fwc_pkg::dist_t                   rd_a,
  output fwc_pkg::dist_t                   ik,
  input  fwc_pkg::relax_t                  relax
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_IK_RD,
    ST_IK_CAP,
    ST_J_RD,
    ST_J_UPD
  } state_t;

  state_t                     state_r, state_nxt;
  fwc_pkg::idx_t              k_r, k_nxt;
  fwc_pkg::idx_t              i_r, i_nxt;
  fwc_pkg::idx_t              j_r, j_nxt;
  fwc_pkg::dist_t             ik_r, ik_nxt;
  logic [fwc_pkg::CNT_W-1:0]  n_used_r, n_used_nxt;
  logic                       out_valid_r, out_valid_nxt;
  fwc_pkg::dist_t             out_dist_r, out_dist_nxt;
  logic                       outside_r, outside_nxt;

  logic [fwc_pkg::CNT_W-1:0]  n_eff;
  logic [fwc_pkg::CNT_W-1:0]  n_last;
  fwc_pkg::idx_t              last_idx;
  logic                       accept;
  logic                       in_range;
  fwc_pkg::addr_t             in_addr;

  always_comb begin
    n_eff    = (n_used_r > fwc_pkg::N_MAX) ? fwc_pkg::N_MAX : n_used_r;
    n_last   = n_eff - fwc_pkg::CNT_W'(1);
    last_idx = n_last[fwc_pkg::IDX_W-1:0];
    in_ready = (state_r == ST_IDLE);
    accept   = in_valid && in_ready;
    in_range = ({1'b0, in_row} < fwc_pkg::N_MAX) && ({1'b0, in_col} < fwc_pkg::N_MAX);
    in_addr  = {in_row[fwc_pkg::IDX_W-1:0], in_col[fwc_pkg::IDX_W-1:0]};

    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ik_nxt        = ik_r;
    n_used_nxt    = cfg_we ? cfg_data : n_used_r;
    outside_nxt   = outside_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dist_nxt  = out_dist_r;

    mem_req         = '0;
    mem_req.raddr_a = {k_r, j_r};
    mem_req.raddr_b = {i_r, j_r};
    mem_req.waddr   = {i_r, j_r};
    mem_req.wdata   = relax.value;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (fwc_pkg::kind_t'(in_kind))
            fwc_pkg::KIND_WRITE: begin
              mem_req.we    = in_range;
              mem_req.waddr = in_addr;
              mem_req.wdata = in_weight;
            end
            fwc_pkg::KIND_RUN: begin
              k_nxt = '0;
              i_nxt = '0;
              j_nxt = '0;
              if (n_eff != '0) begin
                state_nxt = ST_IK_RD;
              end
            end
            fwc_pkg::KIND_READ: begin
              mem_req.re      = 1'b1;
              mem_req.raddr_a = in_addr;
              outside_nxt     = !in_range;
              state_nxt       = ST_RD_WAIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = outside_r ? fwc_pkg::NO_EDGE : rd_a;
          state_nxt     = ST_IDLE;
        end
      end
      ST_IK_RD: begin
        mem_req.re      = 1'b1;
        mem_req.raddr_a = {i_r, k_r};
        state_nxt       = ST_IK_CAP;
      end
      ST_IK_CAP: begin
        ik_nxt    = rd_a;
        state_nxt = ST_J_RD;
      end
      ST_J_RD: begin
        mem_req.re = 1'b1;
        state_nxt  = ST_J_UPD;
      end
      ST_J_UPD: begin
        mem_req.we = relax.upd;
        if (relax.upd && (j_r == k_r)) begin
          ik_nxt = relax.value;
        end
        if (j_r != last_idx) begin
          j_nxt     = j_r + fwc_pkg::IDX_W'(1);
          state_nxt = ST_J_RD;
        end else begin
          j_nxt = '0;
          if (i_r != last_idx) begin
            i_nxt     = i_r + fwc_pkg::IDX_W'(1);
            state_nxt = ST_IK_RD;
          end else begin
            i_nxt = '0;
            if (k_r != last_idx) begin
              k_nxt     = k_r + fwc_pkg::IDX_W'(1);
              state_nxt = ST_IK_RD;
            end else begin
              k_nxt     = '0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      n_used_r    <= fwc_pkg::N_RESET;
      out_valid_r <= 1'b0;
      outside_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      n_used_r    <= n_used_nxt;
      out_valid_r <= out_valid_nxt;
      outside_r   <= outside_nxt;
    end
    ik_r       <= ik_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign ik           = ik_r;

endmodule

`default_nettype wire

/* src/floyd_warshall_closure_unit.sv */
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   in_kind, in_row, in_col, in_weight
// out_     output     out_valid / out_ready out_distance
// cfg_     input      cfg_we                cfg_data (n_used)
//
// A write transaction leaves the block idle, and the next one is accepted right after.
// A read result passes the memory read register and then the output register.
// In a run each relaxation is a read step (ST_J_RD) and a compare and write step
// (ST_J_UPD) on the shared distance memory, and each row first loads its pivot column
// entry (ST_IK_RD, ST_IK_CAP). Reset is synchronous and leaves n_used at 64.
// A result that is not taken holds the block after the following read transaction.
`timescale 1ns / 1ps
`default_nettype none

module floyd_warshall_closure_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [1:0]                       in_kind,
  input  wire  [fwc_pkg::POS_W-1:0]        in_row,
  input  wire  [fwc_pkg::POS_W-1:0]        in_col,
  input  wire  signed [fwc_pkg::DIST_W-1:0] in_weight,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [fwc_pkg::DIST_W-1:0] out_distance,
  input  wire                              cfg_we,
  input  wire  [fwc_pkg::CNT_W-1:0]        cfg_data
);

  fwc_pkg::mem_req_t mem_req;
  fwc_pkg::dist_t    rd_a;
  fwc_pkg::dist_t    rd_b;
  fwc_pkg::dist_t    ik;
  fwc_pkg::relax_t   relax;

  fwc_dist_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  fwc_relax_alu u_alu (
    .ik    (ik),
    .kj    (rd_a),
    .ij    (rd_b),
    .relax (relax)
  );

  fwc_sequencer u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_weight    (in_weight),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .mem_req      (mem_req),
    .rd_a         (rd_a),
    .ik           (ik),
    .relax        (relax)
  );

endmodule

`default_nettype wire

/* src/fwc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module fwc_checker (
  input wire                         clk,
  input wire                         rst_n,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire [1:0]                   in_kind,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [fwc_pkg::DIST_W-1:0]   out_distance
);

  // The block comes out of reset idle and with no pending result.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // A read transaction occupies the block while its result is fetched.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == fwc_pkg::KIND_READ) |=> !in_ready)
    else $error("ready stayed high after a read transaction");

  // A write transaction never stalls the input channel.
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_kind == fwc_pkg::KIND_WRITE) |=> in_ready)
    else $error("write transaction stalled the input");

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_distance)))
    else $error("pending result dropped or changed");

endmodule

bind floyd_warshall_closure_unit fwc_checker u_fwc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_kind      (in_kind),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_distance (out_distance)
);

`default_nettype wire
